// ===== hdl/ist_pkg.sv =====
// shared constants and types for the interpolation search table
package ist_pkg;

    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int PROD_W     = VALUE_W + INDEX_W;
    localparam int STEP_W     = $clog2(INDEX_W);
    localparam int IN_DATA_W  = INDEX_W + 2 * VALUE_W;
    localparam int OUT_DATA_W = INDEX_W;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_LO,
        S_RD_HI,
        S_CMP,
        S_CALC,
        S_TEST,
        S_DONE
    } ist_state_t;

endpackage

// ===== hdl/ist_muldiv.sv =====
// shared multiply and shift-subtract divide unit: floor(a * b / d), quotient below 2**INDEX_W
module ist_muldiv (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ist_pkg::VALUE_W-1:0]   a,
    input  logic [ist_pkg::INDEX_W-1:0]   b,
    input  logic [ist_pkg::VALUE_W-1:0]   d,
    output logic                          done,
    output logic [ist_pkg::INDEX_W-1:0]   q
);
    import ist_pkg::*;

    logic [VALUE_W-1:0] a_reg;
    logic [INDEX_W-1:0] b_reg;
    logic [VALUE_W-1:0] d_reg;
    logic [PROD_W-1:0]  rem_reg;
    logic [INDEX_W-1:0] q_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               mul_reg;
    logic               active_reg;
    logic               done_reg;

    logic [PROD_W-1:0]  trial;
    logic               take;

    // divisor shifted to the current quotient bit
    assign trial = PROD_W'(d_reg) << step_reg;
    assign take  = rem_reg >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg    <= 1'b0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                mul_reg <= 1'b1;
            end
            else if (mul_reg)
            begin
                mul_reg    <= 1'b0;
                active_reg <= 1'b1;
                step_reg   <= STEP_W'(INDEX_W - 1);
            end
            else if (active_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            d_reg <= d;
            q_reg <= '0;
        end
        else if (mul_reg)
        begin
            rem_reg <= PROD_W'(a_reg) * PROD_W'(b_reg);
        end
        else if (active_reg)
        begin
            q_reg <= {q_reg[INDEX_W-2:0], take};
            if (take)
            begin
                rem_reg <= rem_reg - trial;
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

    assert property (@(posedge clk) disable iff (!rst_n) start |=> mul_reg)
        else $error("multiply stage not entered after start");
    assert property (@(posedge clk) disable iff (!rst_n) !(mul_reg && active_reg))
        else $error("multiply and divide overlap");
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> $past(active_reg))
        else $error("done without divide steps");

endmodule

// ===== hdl/interpolation_search_table_top.sv =====
// top level: table store, search sequencer and stream ports
// write request: written to the table as it is accepted, no result
// search request: per probe two table reads, compare, a multiply step,
//   8 divide steps, probe read and test; the result then passes through S_DONE to the output register
// one request at a time; s_tready is high only while the sequencer is idle
// rst_n clears sequencer, output valid and last_index; table contents stay undefined
module interpolation_search_table_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // config: last_index
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ist_pkg::INDEX_W-1:0]       cfg_data,     // last_index
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ist_pkg::IN_DATA_W-1:0]     s_tdata,      // entry_index, entry_value, search_key
    input  logic                              s_tuser,      // cmd
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ist_pkg::OUT_DATA_W-1:0]    m_tdata,      // position
    output logic                              m_tuser       // found
);
    import ist_pkg::*;

    // table storage, one read port with registered data
    logic [VALUE_W-1:0] mem [TABLE_DEPTH];
    logic [VALUE_W-1:0] rdata_reg;
    logic [INDEX_W-1:0] rd_addr;

    ist_state_t state_reg, state_next;

    logic [INDEX_W-1:0]       last_index_reg;
    logic signed [INDEX_W+1:0] low_reg, low_next;    // low can reach depth
    logic signed [INDEX_W+1:0] high_reg, high_next;  // high can reach -1
    logic [VALUE_W-1:0]       key_reg, key_next;
    logic [VALUE_W-1:0]       tl_reg, tl_next;
    logic [INDEX_W-1:0]       pos_reg, pos_next;
    logic                     res_found_reg, res_found_next;
    logic [INDEX_W-1:0]       res_pos_reg, res_pos_next;
    logic                     m_valid_reg, m_valid_next;
    logic                     m_found_reg, m_found_next;
    logic [INDEX_W-1:0]       m_pos_reg, m_pos_next;

    // input fields
    logic               in_cmd;
    logic [INDEX_W-1:0] in_index;
    logic [VALUE_W-1:0] in_value;
    logic [VALUE_W-1:0] in_key;
    logic               accept;
    logic               wr_en;

    // shared arithmetic unit
    logic               md_start;
    logic               md_done;
    logic [INDEX_W-1:0] md_q;
    logic [INDEX_W-1:0] probe;
    logic               in_range;

    assign in_cmd   = s_tuser;
    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_value = s_tdata[INDEX_W+VALUE_W-1:INDEX_W];
    assign in_key   = s_tdata[INDEX_W+2*VALUE_W-1:INDEX_W+VALUE_W];

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign wr_en     = accept && (in_cmd == CMD_WRITE);
    assign cfg_ready = 1'b1;

    // key inside T[low]..T[high]; rdata holds T[high] in the compare state
    assign in_range = ($signed(tl_reg) <= $signed(key_reg))
                   && ($signed(key_reg) <= $signed(rdata_reg));
    assign probe    = low_reg[INDEX_W-1:0] + md_q;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[in_index] <= in_value;
        end
        rdata_reg <= mem[rd_addr];
    end

    ist_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .a     (key_reg - tl_reg),
        .b     (high_reg[INDEX_W-1:0] - low_reg[INDEX_W-1:0]),
        .d     (rdata_reg - tl_reg),
        .done  (md_done),
        .q     (md_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            last_index_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                last_index_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg       <= low_next;
        high_reg      <= high_next;
        key_reg       <= key_next;
        tl_reg        <= tl_next;
        pos_reg       <= pos_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        m_found_reg   <= m_found_next;
        m_pos_reg     <= m_pos_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        key_next       = key_reg;
        tl_next        = tl_reg;
        pos_next       = pos_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        m_valid_next   = m_valid_reg;
        m_found_next   = m_found_reg;
        m_pos_next     = m_pos_reg;
        rd_addr        = '0;
        md_start       = 1'b0;

        // output register drains independently
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_cmd == CMD_SEARCH))
                begin
                    key_next       = in_key;
                    low_next       = '0;
                    high_next      = {2'b00, last_index_reg};
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                    state_next     = S_RD_LO;
                end
            end
            S_RD_LO:
            begin
                if (low_reg > high_reg)
                begin
                    // range emptied
                    state_next = S_DONE;
                end
                else
                begin
                    rd_addr    = low_reg[INDEX_W-1:0];
                    state_next = S_RD_HI;
                end
            end
            S_RD_HI:
            begin
                tl_next    = rdata_reg;
                rd_addr    = high_reg[INDEX_W-1:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (!in_range)
                begin
                    state_next = S_DONE;
                end
                else if ((low_reg == high_reg) || (tl_reg == rdata_reg))
                begin
                    // single entry left or equal ends: key equals T[low]
                    res_found_next = (tl_reg == key_reg);
                    res_pos_next   = (tl_reg == key_reg) ? low_reg[INDEX_W-1:0] : '0;
                    state_next     = S_DONE;
                end
                else
                begin
                    md_start   = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (md_done)
                begin
                    rd_addr    = probe;
                    pos_next   = probe;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (rdata_reg == key_reg)
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = pos_reg;
                    state_next     = S_DONE;
                end
                else if ($signed(rdata_reg) < $signed(key_reg))
                begin
                    low_next   = $signed({2'b00, pos_reg}) + 10'sd1;
                    state_next = S_RD_LO;
                end
                else
                begin
                    high_next  = $signed({2'b00, pos_reg}) - 10'sd1;
                    state_next = S_RD_LO;
                end
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_found_next = res_found_reg;
                    m_pos_next   = res_pos_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = m_pos_reg;

    // a miss always reports position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("not-found result with nonzero position");
    // every probe lies inside the current window
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TEST) |->
            ($signed({2'b00, pos_reg}) >= low_reg) && ($signed({2'b00, pos_reg}) <= high_reg))
        else $error("probe outside search window");
    // divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> (state_reg == S_CALC))
        else $error("divider result with no waiting probe");
    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_pos_reg)))
        else $error("pending result lost");

endmodule

// ===== dv/ist_lookup_checker.sv =====
// checker: mirrors the table and last_index, predicts search results and compares them
module ist_lookup_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [ist_pkg::INDEX_W-1:0]    cfg_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [ist_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ist_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           m_tuser,
    output int                             err_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ist_pkg::*;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] position;
    } lookup_t;

    longint      tbl [TABLE_DEPTH];
    int          last_idx;
    lookup_t     lookup_q [$];
    lookup_t     got;
    lookup_t     want;

    initial
    begin
        err_count = 0;
        pending   = 0;
        last_idx  = 0;
        foreach (tbl[i])
            tbl[i] = 0;
    end

    // interpolation search over entries 0..last_idx, exact 64-bit arithmetic
    function automatic lookup_t interp_lookup(input longint key);
        lookup_t res;
        int      lo;
        int      hi;
        int      probe;
        longint  tl;
        longint  th;
        res = '0;
        lo  = 0;
        hi  = last_idx;
        while (lo <= hi && tbl[lo] <= key && key <= tbl[hi])
        begin
            tl = tbl[lo];
            th = tbl[hi];
            if (lo == hi || tl == th)
            begin
                if (tl == key)
                begin
                    res.found    = 1'b1;
                    res.position = lo[INDEX_W-1:0];
                end
                return res;
            end
            probe = lo + int'(((key - tl) * longint'(hi - lo)) / (th - tl));
            if (tbl[probe] == key)
            begin
                res.found    = 1'b1;
                res.position = probe[INDEX_W-1:0];
                return res;
            end
            if (tbl[probe] < key)
                lo = probe + 1;
            else
                hi = probe - 1;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_idx = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.found    = m_tuser;
                got.position = m_tdata;
                if (lookup_q.size() == 0)
                begin
                    if (err_count < 10)
                        $display("result with nothing outstanding: found=%0b position=%0d",
                                 got.found, got.position);
                    err_count++;
                end
                else
                begin
                    want = lookup_q.pop_front();
                    if (got.found !== want.found || got.position !== want.position)
                    begin
                        if (err_count < 10)
                            $display("mismatch: exp found=%0b pos=%0d, got found=%0b pos=%0d",
                                     want.found, want.position, got.found, got.position);
                        err_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                last_idx = int'(cfg_data);
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == CMD_WRITE)
                    tbl[s_tdata[INDEX_W-1:0]] =
                        longint'($signed(s_tdata[INDEX_W +: VALUE_W]));
                else
                    lookup_q.push_back(interp_lookup(
                        longint'($signed(s_tdata[INDEX_W+VALUE_W +: VALUE_W]))));
            end
            pending = lookup_q.size();
        end
    end

endmodule

// ===== dv/tb_interpolation_search_table_top.sv =====
// testbench top: clock, reset, request and config stimulus, result sink and verdict
module tb_interpolation_search_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ist_pkg::*;

    // run shape
    localparam int ITEM_TARGET   = 850;
    localparam int PHASE_A_END   = 283;   // sender idles 30, receiver 58
    localparam int PHASE_B_END   = 566;   // sender idles 58, receiver 30
    localparam int HOLD_AT       = 650;   // long receiver hold-off starts here
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 20;    // writes give no result, let the block go idle
    localparam int DRAIN_CYCLES  = 50;
    localparam int TAIL_ITEMS    = 300;   // near the end only short reloads

    localparam logic [VALUE_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
    localparam longint VAL_MIN = -64'sd2147483648;
    localparam longint VAL_MAX = 64'sd2147483647;

    // shapes for loading entries 0..last_index
    typedef enum int {
        FILL_SPREAD,   // ascending over the full signed range
        FILL_STEPS,    // ascending in tiny steps, many duplicates
        FILL_FLAT,     // all entries equal
        FILL_SKEW,     // ascending, strongly non-linear
        FILL_NOISE,    // random, out of order
        FILL_FALL      // descending
    } fill_kind_e;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [INDEX_W-1:0]    cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;    // entry_index, entry_value, search_key
    logic                  s_tuser;    // cmd
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;    // position
    logic                  m_tuser;    // found

    int     err_count;
    int     pending;
    int     sent_count;
    longint tbl_img [TABLE_DEPTH];     // stimulus-side image, used to pick keys

    interpolation_search_table_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    ist_lookup_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .err_count (err_count),
        .pending   (pending)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #200_000_000;
        $display("tb_interpolation_search_table_top: errors");
        $finish;
    end

    // one request: random gap first, then hold valid until the block takes it
    // valid stays high across back-to-back requests
    task automatic push_request(input logic cmd, input logic [INDEX_W-1:0] idx,
                                input logic [VALUE_W-1:0] val, input logic [VALUE_W-1:0] key);
        int idle_pct;
        idle_pct = (sent_count < PHASE_A_END) ? 30 : (sent_count < PHASE_B_END) ? 58 : 0;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {key, val, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (cmd == CMD_WRITE)
            tbl_img[idx] = longint'($signed(val));
        sent_count++;
    endtask

    // write request, unused key field carries random bits
    task automatic write_entry(input logic [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] val);
        push_request(CMD_WRITE, idx, val, $urandom);
    endtask

    // search request, unused index and value fields carry random bits
    task automatic search_for(input logic [VALUE_W-1:0] key);
        push_request(CMD_SEARCH, INDEX_W'($urandom), $urandom, key);
    endtask

    // last_index only changes while the block is idle: nothing outstanding plus settle time
    task automatic set_last_index(input int unsigned val);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= val[INDEX_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result sink: random stalls per phase, one long hold-off to back up the input
    initial
    begin
        bit held;
        int stall_pct;
        int hold_n;
        held     = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && sent_count >= HOLD_AT)
            begin
                held     = 1'b1;
                m_tready <= 1'b0;
                for (hold_n = 0; hold_n < HOLD_CYCLES; hold_n++)
                    @(posedge clk);
            end
            stall_pct = (sent_count < PHASE_A_END) ? 58 : (sent_count < PHASE_B_END) ? 30 : 0;
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // main stimulus
    initial
    begin
        int            round_n;
        int unsigned   last;
        int unsigned   ops;
        int unsigned   pick;
        int unsigned   j;
        int            i;
        fill_kind_e    kind;
        longint        cur;
        longint        span;
        logic [VALUE_W-1:0] key;
        logic [INDEX_W-1:0] widx;

        sent_count = 0;
        foreach (tbl_img[n])
            tbl_img[n] = 0;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tuser   <= CMD_WRITE;
        s_tdata   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: last_index at its reset value, single entry left
        write_entry(8'd0, KEY_MIN);
        search_for(KEY_MIN);           // hit on the only entry
        search_for(KEY_MAX);           // above the range
        write_entry(8'd0, KEY_MAX);
        search_for(KEY_MAX);
        search_for(KEY_MIN);           // below the range

        // full signed span across two entries, value difference at its widest
        set_last_index(1);
        write_entry(8'd1, KEY_MAX);
        write_entry(8'd0, KEY_MIN);
        search_for(32'd0);             // miss between the ends
        search_for(KEY_MIN);
        search_for(KEY_MAX);

        // equal ends: no division, hit at low
        set_last_index(3);
        for (i = 0; i < 4; i++)
            write_entry(i[INDEX_W-1:0], 32'd7);
        search_for(32'd7);
        search_for(32'd8);

        // table out of order at the ends
        write_entry(8'd0, 32'd10);
        search_for(32'd7);

        // top index, outside the searched range
        write_entry(8'hFF, $urandom);

        // random rounds: new last_index, reload, then searches mixed with stray writes
        round_n = 0;
        while (sent_count < ITEM_TARGET)
        begin
            if (round_n == 0)
                last = 0;
            else if (round_n == 1)
                last = 255;
            else if (sent_count + TAIL_ITEMS > ITEM_TARGET)
                last = $urandom_range(1, 15);
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    last = 0;
                else if (pick == 1)
                    last = 255;
                else if (pick < 6)
                    last = $urandom_range(1, 15);
                else
                    last = $urandom_range(16, 63);
            end
            set_last_index(last);

            pick = $urandom_range(0, 99);
            if (pick < 25)
                kind = FILL_SPREAD;
            else if (pick < 45)
                kind = FILL_STEPS;
            else if (pick < 55)
                kind = FILL_FLAT;
            else if (pick < 70)
                kind = FILL_SKEW;
            else if (pick < 85)
                kind = FILL_NOISE;
            else
                kind = FILL_FALL;

            // load entries 0..last so no search ever touches an unwritten entry
            span = 64'sd4294967295 / longint'(last + 1);
            cur  = 0;
            for (i = 0; i <= int'(last); i++)
            begin
                case (kind)
                    FILL_SPREAD:
                        if (i == 0)
                            cur = VAL_MIN + longint'($urandom_range(0, 1000));
                        else
                            cur = cur + longint'($urandom) % (2 * span + 1);
                    FILL_STEPS:
                        if (i == 0)
                            cur = longint'($signed($urandom)) / 2;
                        else
                            cur = cur + longint'($urandom_range(0, 3));
                    FILL_FLAT:
                        if (i == 0)
                            cur = longint'($signed($urandom));
                    FILL_SKEW:
                    begin
                        if (i == 0)
                            span = VAL_MIN + longint'($urandom_range(0, 1 << 30));
                        cur = span + longint'(i) * i * i * i;
                    end
                    FILL_NOISE:
                        cur = longint'($signed($urandom));
                    default:
                        if (i == 0)
                            cur = VAL_MAX - longint'($urandom_range(0, 1000));
                        else
                            cur = cur - longint'($urandom_range(0, 1 << 20));
                endcase
                if (cur > VAL_MAX)
                    cur = VAL_MAX;
                if (cur < VAL_MIN)
                    cur = VAL_MIN;
                write_entry(i[INDEX_W-1:0], cur[VALUE_W-1:0]);
            end

            ops = $urandom_range(12, 28);
            repeat (ops)
            begin
                pick = $urandom_range(0, 99);
                j    = $urandom_range(0, last);
                if (pick < 8)
                begin
                    // duplicate a neighbor, keeps an ordered table ordered
                    widx = j[INDEX_W-1:0];
                    if (j > 0)
                        write_entry(widx, tbl_img[j - 1][VALUE_W-1:0]);
                    else
                        write_entry(widx, tbl_img[j][VALUE_W-1:0]);
                end
                else if (pick < 15)
                    write_entry(INDEX_W'($urandom), $urandom);   // noise anywhere in the table
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 55)
                        key = tbl_img[j][VALUE_W-1:0];
                    else if (pick < 65)
                        key = tbl_img[j][VALUE_W-1:0] + 32'd1;
                    else if (pick < 72)
                        key = tbl_img[j][VALUE_W-1:0] - 32'd1;
                    else if (pick < 80)
                        key = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
                    else
                        key = $urandom;
                    search_for(key);
                end
            end
            round_n++;
        end

        // drain: all results in, then wait out DRAIN_CYCLES for anything stray
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0 && pending == 0)
            $display("tb_interpolation_search_table_top: clean");
        else
            $display("tb_interpolation_search_table_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ist_pkg.sv
hdl/ist_muldiv.sv
hdl/interpolation_search_table_top.sv
dv/ist_lookup_checker.sv
dv/tb_interpolation_search_table_top.sv
